>>> src/sle_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted list engine
// depends on nothing; used by sle_cell and sorted_list_engine_unit
package sle_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [4:0]            count_field_t;
  typedef logic [31:0]           word_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // per-cell command: insert or delete
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

>>> src/sorted_list_engine_unit.sv
`timescale 1ns / 1ps
// top level of the sorted list engine: chain of cells, count and output register
// depends on sle_pkg and sle_cell

// Keeps up to CAPACITY unsigned values in ascending order in a row of cells,
// one entry per cell. An insert, a delete or a read is done at once in the cells: every
// cell compares its entry with the new value and shifts from its left or
// right neighbor in the same cycle, so a word is accepted every cycle and its
// result appears in the output register on the next one. The input stalls
// only while a finished result is held by a stalled output. Equal values keep
// arrival order; the newest goes after them.
module sorted_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] value,
  input  logic [4:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic [4:0]  count,
  output logic        is_empty,
  output logic [1:0]  status
);

  localparam int CAP = sle_pkg::CAPACITY;

  sle_pkg::data_t     cell_data [CAP];
  logic [CAP-1:0]     cell_occ;
  logic [CAP-1:0]     cell_gt;
  sle_pkg::cell_cmd_t cell_cmd [CAP];

  sle_pkg::cnt_t  entry_count;
  sle_pkg::cnt_t  entry_count_next;
  sle_pkg::data_t ins_value;
  sle_pkg::idx_t  pos_idx;
  logic           accept;
  logic           full;
  logic           pos_bad;
  logic           do_ins;
  logic           do_del;
  logic [1:0]     res_status;
  sle_pkg::word_t res_read;
  logic           sorted_ok;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign ins_value = sle_pkg::data_t'(value);
  assign full      = (entry_count == sle_pkg::cnt_t'(CAP));
  assign pos_bad   = (position == 5'd0) ||
                     (sle_pkg::cmp_t'(position) > sle_pkg::cmp_t'(entry_count));
  assign pos_idx   = sle_pkg::idx_t'(position - 5'd1);

  always_comb begin
    do_ins           = 1'b0;
    do_del           = 1'b0;
    res_status       = sle_pkg::ST_OK;
    res_read         = '0;
    entry_count_next = entry_count;
    case (action)
      sle_pkg::ACT_INSERT: begin
        if (full) begin
          res_status = sle_pkg::ST_FULL;
        end else begin
          do_ins           = accept;
          entry_count_next = entry_count + sle_pkg::cnt_t'(1);
        end
      end
      sle_pkg::ACT_DELETE: begin
        if (pos_bad) begin
          res_status = sle_pkg::ST_RANGE;
        end else begin
          do_del           = accept;
          entry_count_next = entry_count - sle_pkg::cnt_t'(1);
        end
      end
      sle_pkg::ACT_READ: begin
        if (pos_bad) begin
          res_status = sle_pkg::ST_RANGE;
        end else begin
          res_read = sle_pkg::word_t'(cell_data[pos_idx]);
        end
      end
      default: begin
        res_status = sle_pkg::ST_OK;
      end
    endcase
  end

  for (genvar k = 0; k < CAP; k++) begin : g_cell
    sle_pkg::data_t l_data;
    sle_pkg::data_t r_data;
    logic           l_occ;
    logic           l_gt;
    logic           r_occ;

    // delete shifts every cell at or after the removed position
    assign cell_cmd[k].ins = do_ins;
    assign cell_cmd[k].del = do_del &&
      (sle_pkg::cmp_t'(k) + sle_pkg::cmp_t'(1) >= sle_pkg::cmp_t'(position));

    if (k == 0) begin : g_first
      assign l_data = '0;
      assign l_occ  = 1'b1;
      assign l_gt   = 1'b0;
    end else begin : g_mid_l
      assign l_data = cell_data[k-1];
      assign l_occ  = cell_occ[k-1];
      assign l_gt   = cell_gt[k-1];
    end

    if (k == CAP - 1) begin : g_last
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[k+1];
      assign r_occ  = cell_occ[k+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd[k]),
      .ins_value  (ins_value),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .left_gt    (l_gt),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[k]),
      .occ        (cell_occ[k]),
      .gt         (cell_gt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept) begin
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= res_read;
      count      <= sle_pkg::count_field_t'(entry_count_next);
      is_empty   <= (entry_count_next == '0);
      status     <= res_status;
    end
  end

  // occupied neighbors must be in ascending order
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i + 1 < CAP; i++) begin
      if (cell_occ[i+1] && (cell_data[i] > cell_data[i+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_matches_cells : assert property (@(posedge clk) disable iff (rst)
    $countones(cell_occ) == int'(entry_count))
    else $error("occupied cells disagree with entry count");

  // one extra bit so a completely full row still carries into a single one
  a_cells_packed : assert property (@(posedge clk) disable iff (rst)
    $countones({1'b0, cell_occ} + {{CAP{1'b0}}, 1'b1}) == 1)
    else $error("occupied cells are not a contiguous run from cell zero");

  a_sorted : assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("list lost ascending order");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (is_empty == (entry_count == '0)))
    else $error("accepted word did not produce a matching result");

endmodule

>>> src/sle_cell.sv
`timescale 1ns / 1ps
// one list cell: holds an entry and its occupied flag, shifts with its neighbors
// depends on sle_pkg
module sle_cell (
  input  logic              clk,
  input  logic              rst,
  input  sle_pkg::cell_cmd_t cmd,
  input  sle_pkg::data_t    ins_value,
  input  sle_pkg::data_t    left_data,
  input  logic              left_occ,
  input  logic              left_gt,
  input  sle_pkg::data_t    right_data,
  input  logic              right_occ,
  output sle_pkg::data_t    data,
  output logic              occ,
  output logic              gt
);

  assign gt = occ && (data > ins_value);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // larger entries move one cell right, new word lands in the first gap
      if (left_gt) begin
        data <= left_data;
      end else if (gt || (!occ && left_occ)) begin
        data <= ins_value;
      end
    end else if (cmd.del) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.ins) begin
      if (left_gt || (!occ && left_occ)) begin
        occ <= 1'b1;
      end
    end else if (cmd.del) begin
      occ <= right_occ;
    end
  end

endmodule

>>> tb/tb_sorted_list_engine_unit.sv
`timescale 1ns / 1ps
// testbench for sorted_list_engine_unit: directed corners, a fill under output
// back-pressure and random traffic, checked against an in-bench sorted list
// depends on sle_pkg and the sorted_list_engine_unit rtl
module tb_sorted_list_engine_unit;

  localparam int             LIMIT_CYCLES = 200000;
  localparam int             DRAIN_CYCLES = 4;
  localparam logic [1:0]     ACT_UNUSED   = 2'd3;
  localparam sle_pkg::data_t DATA_MAX     = '1;

  typedef struct {
    sle_pkg::data_t        read_value;
    sle_pkg::count_field_t count;
    logic                  is_empty;
    sle_pkg::status_t      status;
  } list_result_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  action     = sle_pkg::ACT_INSERT;
  logic [31:0] value      = '0;
  logic [4:0]  position   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] read_value;
  logic [4:0]  count;
  logic        is_empty;
  logic [1:0]  status;

  // in-bench copy of the list, ascending
  sle_pkg::data_t sorted_entries[$];
  list_result_t   pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int n_checked      = 0;
  int n_insert       = 0;
  int n_delete       = 0;
  int n_read         = 0;
  int n_full         = 0;
  int n_range        = 0;

  sorted_list_engine_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic list_result_t predict_list_op(input logic [1:0] act,
                                                   input sle_pkg::data_t val,
                                                   input logic [4:0] pos);
    list_result_t res;
    int           slot;
    res.read_value = '0;
    res.status     = sle_pkg::ST_OK;
    case (act)
      sle_pkg::ACT_INSERT: begin
        n_insert++;
        if (sorted_entries.size() >= sle_pkg::CAPACITY) begin
          res.status = sle_pkg::ST_FULL;
          n_full++;
        end else begin
          // new value goes after every entry that is not greater
          slot = 0;
          while (slot < sorted_entries.size() && sorted_entries[slot] <= val) slot++;
          sorted_entries.insert(slot, val);
        end
      end
      sle_pkg::ACT_DELETE, sle_pkg::ACT_READ: begin
        if (act == sle_pkg::ACT_READ) n_read++;
        else n_delete++;
        if (pos == 0 || pos > sorted_entries.size()) begin
          res.status = sle_pkg::ST_RANGE;
          n_range++;
        end else if (act == sle_pkg::ACT_READ) begin
          res.read_value = sorted_entries[pos - 1];
        end else begin
          sorted_entries.delete(pos - 1);
        end
      end
      default: ;
    endcase
    res.count    = sle_pkg::count_field_t'(sorted_entries.size());
    res.is_empty = (sorted_entries.size() == 0);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  // result checker, one word per accepted handshake
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result word with nothing expected, count %0d", count));
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value)
          note_mismatch($sformatf("word %0d read_value %h, want %h", n_checked, read_value,
                                  want.read_value));
        if (count !== want.count)
          note_mismatch($sformatf("word %0d count %0d, want %0d", n_checked, count,
                                  want.count));
        if (is_empty !== want.is_empty)
          note_mismatch($sformatf("word %0d is_empty %b, want %b", n_checked, is_empty,
                                  want.is_empty));
        if (status !== want.status)
          note_mismatch($sformatf("word %0d status %0d, want %0d", n_checked, status,
                                  want.status));
      end
      n_checked++;
    end
  end

  // receiver stall, forced high while a hold-off is running
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic [1:0] act, input sle_pkg::data_t val,
                           input logic [4:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_list_op(act, val, pos));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    send_word(sle_pkg::ACT_READ, '0, 5'd1);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd1);
    send_word(ACT_UNUSED, DATA_MAX, 5'd31);
    send_word(sle_pkg::ACT_INSERT, DATA_MAX, 5'd0);
    send_word(sle_pkg::ACT_INSERT, '0, 5'd0);
    send_word(sle_pkg::ACT_INSERT, 32'h8000_0000, 5'd0);
    send_word(sle_pkg::ACT_INSERT, 32'h8000_0000, 5'd0);
    send_word(sle_pkg::ACT_INSERT, 32'h0000_0001, 5'd0);
    send_word(sle_pkg::ACT_INSERT, 32'h7fff_ffff, 5'd0);
    send_word(sle_pkg::ACT_READ, '0, 5'd0);
    send_word(sle_pkg::ACT_READ, '0, 5'd1);
    send_word(sle_pkg::ACT_READ, '0, 5'd6);
    send_word(sle_pkg::ACT_READ, '0, 5'd7);
    send_word(sle_pkg::ACT_READ, '0, 5'd31);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd0);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd31);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd6);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd1);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd2);
    for (int p = 1; p <= 3; p++) send_word(sle_pkg::ACT_READ, '0, 5'(p));
    send_word(ACT_UNUSED, 32'h5a5a_a5a5, 5'd16);
    for (int p = 3; p >= 1; p--) send_word(sle_pkg::ACT_DELETE, '0, 5'(p));
    wait_results_drained();
  endtask

  // receiver holds off while inserts keep coming: the block backs up and
  // the list overflows
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left <= 300;
    for (int i = 0; i < 20; i++)
      send_word(sle_pkg::ACT_INSERT, $urandom_range(0, 15), 5'd0);
    send_word(sle_pkg::ACT_READ, '0, 5'd16);
    send_word(sle_pkg::ACT_READ, '0, 5'd17);
    send_word(sle_pkg::ACT_DELETE, '0, 5'd16);
    send_word(sle_pkg::ACT_INSERT, DATA_MAX, 5'd0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n_words, input int s_idle, input int r_stall);
    int             roll;
    int             ins_pct;
    logic [1:0]     act;
    sle_pkg::data_t val;
    logic [4:0]     pos;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n_words; i++) begin
      // alternate fill-heavy and drain-heavy stretches so full and empty recur
      ins_pct = ((i / 48) % 2 == 0) ? 62 : 24;
      roll = $urandom_range(0, 99);
      if (roll < 2) act = ACT_UNUSED;
      else if (roll < 2 + ins_pct) act = sle_pkg::ACT_INSERT;
      else if ($urandom_range(0, 1) == 0) act = sle_pkg::ACT_DELETE;
      else act = sle_pkg::ACT_READ;
      roll = $urandom_range(0, 99);
      if (roll < 15) val = $urandom_range(0, 7);
      else if (roll < 20) val = ($urandom_range(0, 1) == 0) ? '0 : DATA_MAX;
      else val = $urandom;
      if (sorted_entries.size() != 0 && $urandom_range(0, 99) < 85)
        pos = 5'($urandom_range(1, sorted_entries.size()));
      else
        pos = 5'($urandom_range(0, 31));
      send_word(act, val, pos);
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_backpressure_fill();
    test_random_traffic(360, 0, 0);
    test_random_traffic(360, 48, 0);
    test_random_traffic(360, 0, 48);
    test_random_traffic(360, 28, 28);
    $display("covered %0d inserts (%0d into a full list), %0d deletes, %0d reads",
             n_insert, n_full, n_delete, n_read);
    $display("%0d requests out of range, %0d result words checked in %0d cycles",
             n_range, n_checked, cycle_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
